/* hdl/nfcrx_pkg.sv */
// ============================================================================
// nfcrx_pkg
// Shared types and constants for the NFC response frame receiver: the parse
// phase encoding, the result status codes and the fixed frame byte values.
// ============================================================================
package nfcrx_pkg;

   // Parse phase of the frame receiver.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_PRE1  = 4'd1,
      PH_PRE2  = 4'd2,
      PH_LEN   = 4'd3,
      PH_LCS   = 4'd4,
      PH_XLENH = 4'd5,
      PH_XLENL = 4'd6,
      PH_XLCS  = 4'd7,
      PH_TFI   = 4'd8,
      PH_RSP   = 4'd9,
      PH_ERRC  = 4'd10,
      PH_DATA  = 4'd11,
      PH_DCS   = 4'd12,
      PH_POST  = 4'd13
   } phase_type;

   // Status reported with each result.
   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_OK       = 3'd1,
      ST_PREAMBLE = 3'd2,
      ST_HEADER   = 3'd3,
      ST_XLCS     = 3'd4,
      ST_DCS      = 3'd5,
      ST_POST     = 3'd6,
      ST_ERRFRAME = 3'd7
   } status_type;

   // Fixed byte values of the frame format.
   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_START     = 8'hFF;
   localparam logic [7:0] BYTE_TFI_RESP  = 8'hD5;
   localparam logic [7:0] BYTE_TFI_ERROR = 8'h7F;
   localparam logic [7:0] BYTE_ERROR_DCS = 8'h81;

   // Smallest length of a normal response: TFI plus response code.
   localparam logic [15:0] MIN_RESP_LEN  = 16'd2;
   localparam logic [15:0] ERROR_LEN     = 16'd1;

endpackage

/* hdl/nfc_response_frame_receiver_core.sv */
// ============================================================================
// nfc_response_frame_receiver_core
// Parses NFC controller response frames from a received byte stream and
// reports payload bytes and the end-of-frame status.
// ============================================================================
// The block takes one received byte per transfer and returns exactly one
// result per byte, written to the result register once the byte has passed
// the input register, so one byte per clock is sustained with no stall on the
// result side. Each result carries either a payload byte (payload_valid set),
// a plain busy indication, or, on the byte that ends or aborts a frame,
// frame_end with a status: ok, bad preamble, bad header, bad extended length
// checksum, bad data checksum, bad postamble or error frame. After frame_end
// the receiver waits for the next preamble. The expected command is sampled
// with the first preamble byte of each frame. Each request passes through an
// input register and a result register, with the per-byte parse step between
// them.
module nfc_response_frame_receiver_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_expected_command,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_frame_end,
   output logic [2:0] rsp_status
);

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] in_cmd_ff;

   // Parser state.
   nfcrx_pkg::phase_type phase_ff, phase_in;
   logic [15:0] length_hold_ff, length_hold_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  latched_cmd_ff, latched_cmd_in;
   logic        is_error_ff, is_error_in;

   // Result register.
   logic       out_vld_ff;
   logic [7:0] out_pay_ff;
   logic       out_pvld_ff;
   logic       out_end_ff;
   nfcrx_pkg::status_type out_st_ff;

   // Step outputs.
   logic [7:0] pay_c;
   logic       pvld_c;
   logic       end_c;
   nfcrx_pkg::status_type st_c;

   logic move;
   logic step;

   // The result register advances when it is empty or being taken.
   assign move      = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && move;
   assign req_stall = in_vld_ff && !move;

   // Input register loads on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
         in_cmd_ff  <= req_expected_command;
      end
   end

   // Per-byte parse step: next state and the result of this byte.
   always_comb begin
      phase_in       = phase_ff;
      length_hold_in = length_hold_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      latched_cmd_in = latched_cmd_ff;
      is_error_in    = is_error_ff;
      pay_c          = 8'h00;
      pvld_c         = 1'b0;
      end_c          = 1'b0;
      st_c           = nfcrx_pkg::ST_BUSY;
      unique case (phase_ff)
         nfcrx_pkg::PH_PRE1: begin
            if (in_byte_ff == nfcrx_pkg::BYTE_ZERO) begin
               phase_in = nfcrx_pkg::PH_PRE2;
            end else begin
               st_c  = nfcrx_pkg::ST_PREAMBLE;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_PRE2: begin
            if (in_byte_ff == nfcrx_pkg::BYTE_START) begin
               phase_in = nfcrx_pkg::PH_LEN;
            end else begin
               st_c  = nfcrx_pkg::ST_PREAMBLE;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_LEN: begin
            length_hold_in = {8'h00, in_byte_ff};
            phase_in       = nfcrx_pkg::PH_LCS;
         end
         nfcrx_pkg::PH_LCS: begin
            // Length FF with checksum FF marks an extended frame.
            if (length_hold_ff == {8'h00, nfcrx_pkg::BYTE_START} &&
                in_byte_ff == nfcrx_pkg::BYTE_START) begin
               phase_in = nfcrx_pkg::PH_XLENH;
            end else if (8'(length_hold_ff[7:0] + in_byte_ff) == 8'h00) begin
               phase_in = nfcrx_pkg::PH_TFI;
            end else begin
               st_c  = nfcrx_pkg::ST_HEADER;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_XLENH: begin
            length_hold_in = {in_byte_ff, 8'h00};
            running_sum_in = in_byte_ff;
            phase_in       = nfcrx_pkg::PH_XLENL;
         end
         nfcrx_pkg::PH_XLENL: begin
            length_hold_in = {length_hold_ff[15:8], in_byte_ff};
            running_sum_in = 8'(running_sum_ff + in_byte_ff);
            phase_in       = nfcrx_pkg::PH_XLCS;
         end
         nfcrx_pkg::PH_XLCS: begin
            if (8'(running_sum_ff + in_byte_ff) == 8'h00) begin
               phase_in = nfcrx_pkg::PH_TFI;
            end else begin
               st_c  = nfcrx_pkg::ST_XLCS;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_TFI: begin
            running_sum_in = in_byte_ff;
            if (in_byte_ff == nfcrx_pkg::BYTE_TFI_RESP &&
                length_hold_ff >= nfcrx_pkg::MIN_RESP_LEN) begin
               phase_in = nfcrx_pkg::PH_RSP;
            end else if (in_byte_ff == nfcrx_pkg::BYTE_TFI_ERROR &&
                         length_hold_ff == nfcrx_pkg::ERROR_LEN) begin
               is_error_in = 1'b1;
               phase_in    = nfcrx_pkg::PH_ERRC;
            end else begin
               st_c  = nfcrx_pkg::ST_HEADER;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_RSP: begin
            // The response code is the command plus one, wrapping at 8 bits.
            if (in_byte_ff == 8'(latched_cmd_ff + 8'd1)) begin
               running_sum_in = 8'(running_sum_ff + in_byte_ff);
               bytes_left_in  = 16'(length_hold_ff - nfcrx_pkg::MIN_RESP_LEN);
               phase_in       = (length_hold_ff == nfcrx_pkg::MIN_RESP_LEN) ?
                                nfcrx_pkg::PH_DCS : nfcrx_pkg::PH_DATA;
            end else begin
               st_c  = nfcrx_pkg::ST_HEADER;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_ERRC: begin
            if (in_byte_ff == nfcrx_pkg::BYTE_ERROR_DCS) begin
               phase_in = nfcrx_pkg::PH_POST;
            end else begin
               st_c  = nfcrx_pkg::ST_HEADER;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_DATA: begin
            pay_c          = in_byte_ff;
            pvld_c         = 1'b1;
            running_sum_in = 8'(running_sum_ff + in_byte_ff);
            bytes_left_in  = 16'(bytes_left_ff - 16'd1);
            if (bytes_left_ff == 16'd1) begin
               phase_in = nfcrx_pkg::PH_DCS;
            end
         end
         nfcrx_pkg::PH_DCS: begin
            if (8'(running_sum_ff + in_byte_ff) == 8'h00) begin
               phase_in = nfcrx_pkg::PH_POST;
            end else begin
               st_c  = nfcrx_pkg::ST_DCS;
               end_c = 1'b1;
            end
         end
         nfcrx_pkg::PH_POST: begin
            end_c = 1'b1;
            if (in_byte_ff == nfcrx_pkg::BYTE_ZERO) begin
               st_c = is_error_ff ? nfcrx_pkg::ST_ERRFRAME : nfcrx_pkg::ST_OK;
            end else begin
               st_c = nfcrx_pkg::ST_POST;
            end
         end
         default: begin
            // Idle, and any unused phase code: start of a new frame.
            latched_cmd_in = in_cmd_ff;
            is_error_in    = 1'b0;
            length_hold_in = 16'h0000;
            bytes_left_in  = 16'h0000;
            running_sum_in = 8'h00;
            if (in_byte_ff == nfcrx_pkg::BYTE_ZERO) begin
               phase_in = nfcrx_pkg::PH_PRE1;
            end else begin
               st_c  = nfcrx_pkg::ST_PREAMBLE;
               end_c = 1'b1;
            end
         end
      endcase
      if (end_c) begin
         phase_in = nfcrx_pkg::PH_IDLE;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= nfcrx_pkg::PH_IDLE;
         length_hold_ff <= 16'h0000;
         bytes_left_ff  <= 16'h0000;
         running_sum_ff <= 8'h00;
         latched_cmd_ff <= 8'h00;
         is_error_ff    <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         length_hold_ff <= length_hold_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
         latched_cmd_ff <= latched_cmd_in;
         is_error_ff    <= is_error_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move) begin
         out_vld_ff <= in_vld_ff;
      end
      if (step) begin
         out_pay_ff  <= pay_c;
         out_pvld_ff <= pvld_c;
         out_end_ff  <= end_c;
         out_st_ff   <= st_c;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_payload_byte  = out_pay_ff;
   assign rsp_payload_valid = out_pvld_ff;
   assign rsp_frame_end     = out_end_ff;
   assign rsp_status        = out_st_ff;

   // A payload byte never ends a frame.
   a_payload_not_end: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_pvld_ff) |-> !out_end_ff)
      else $error("payload result also marked frame end");

   // A result that does not end the frame reports busy.
   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_end_ff) |-> (out_st_ff == nfcrx_pkg::ST_BUSY))
      else $error("non-final result carries a status");

   // A byte that ends a frame returns the parser to idle.
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step && end_c) |=> (phase_ff == nfcrx_pkg::PH_IDLE))
      else $error("parser not idle after frame end");

   // A processed byte always yields a result in the next cycle.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_vld_ff)
      else $error("processed byte produced no result");

endmodule
